FILE: src/mdfe_pkg.sv
package mdfe_pkg;

  localparam int BUF_DEPTH_DEF = 64;
  localparam int MARK_LEN      = 4;
  localparam int CFG_WIDTH     = 32;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  localparam logic [1:0] ST_PAYLOAD = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_OVF     = 2'd2;

  localparam logic CFG_BEGIN = 1'b0;
  localparam logic CFG_END   = 1'b1;

  typedef struct packed {
    logic load_byte;
    logic eval;
    logic rd_en;
    logic dump_out;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic in_frame;
    logic end_done;
    logic empty;
    logic last_rd;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] marker_byte(input logic [31:0] marker, input logic [1:0] pos);
    marker_byte = marker[{pos, 3'b000} +: 8] & BYTE_MASK;
  endfunction

  function automatic logic [2:0] advance_match(input logic [31:0] marker,
                                               input logic [2:0] matched,
                                               input logic [7:0] v);
    if ((matched < 3'(MARK_LEN)) && (v == marker_byte(marker, matched[1:0]))) begin
      advance_match = matched + 3'd1;
    end else begin
      advance_match = (v == marker_byte(marker, 2'd0)) ? 3'd1 : 3'd0;
    end
  endfunction

endpackage

FILE: src/mdfe_ram.sv
module mdfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/mdfe_ctrl.sv
module mdfe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mdfe_pkg::sts_t     sts,
  output mdfe_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       needs_out;

  assign in_ready  = (state_r == S_IDLE);
  assign needs_out = sts.ovf || (sts.in_frame && sts.end_done && sts.empty);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          state_nxt     = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!needs_out || sts.out_free) begin
          cmd.eval = 1'b1;
          if (!sts.ovf && sts.in_frame && sts.end_done && !sts.empty) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.dump_out = 1'b1;
          state_nxt    = sts.last_rd ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/mdfe_dp.sv
module mdfe_dp #(
  parameter int BUF_DEPTH = mdfe_pkg::BUF_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [mdfe_pkg::CFG_WIDTH-1:0]  cfg_wdata,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_payload_byte,
  output logic [1:0]                      out_status,
  output logic                            out_last,
  input  mdfe_pkg::cmd_t                  cmd,
  output mdfe_pkg::sts_t                  sts
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  logic [31:0]   begin_marker_r;
  logic [31:0]   end_marker_r;
  logic [7:0]    byte_r;
  logic [2:0]    begin_matched_r, begin_matched_nxt;
  logic [2:0]    end_matched_r, end_matched_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_payload_r, out_payload_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic          out_last_r, out_last_nxt;
  logic [2:0]    begin_adv;
  logic [2:0]    end_adv;
  logic [CW-1:0] frame_len;
  logic          ram_we;
  logic [7:0]    ram_q;

  assign begin_adv = mdfe_pkg::advance_match(begin_marker_r, begin_matched_r, byte_r);
  assign end_adv   = mdfe_pkg::advance_match(end_marker_r, end_matched_r, byte_r);
  assign frame_len = count_r - CW'(mdfe_pkg::MARK_LEN);

  assign sts.ovf      = (count_r == CW'(BUF_DEPTH));
  assign sts.in_frame = (begin_matched_r == 3'(mdfe_pkg::MARK_LEN));
  assign sts.end_done = (end_adv == 3'(mdfe_pkg::MARK_LEN));
  assign sts.empty    = (count_r == CW'(mdfe_pkg::MARK_LEN - 1));
  assign sts.last_rd  = ((rd_idx_r + CW'(1)) == frame_len);
  assign sts.out_free = !out_valid_r || out_ready;

  assign ram_we = cmd.eval && !sts.ovf && sts.in_frame;

  mdfe_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (byte_r),
    .re    (cmd.rd_en),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_q)
  );

  always_comb begin
    begin_matched_nxt = begin_matched_r;
    end_matched_nxt   = end_matched_r;
    count_nxt         = count_r;
    rd_idx_nxt        = rd_idx_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_payload_nxt   = out_payload_r;
    out_status_nxt    = out_status_r;
    out_last_nxt      = out_last_r;
    if (cmd.eval) begin
      rd_idx_nxt = '0;
      if (sts.ovf) begin
        begin_matched_nxt = '0;
        end_matched_nxt   = '0;
        count_nxt         = '0;
        out_valid_nxt     = 1'b1;
        out_payload_nxt   = '0;
        out_status_nxt    = mdfe_pkg::ST_OVF;
        out_last_nxt      = 1'b1;
      end else if (!sts.in_frame) begin
        begin_matched_nxt = begin_adv;
      end else begin
        count_nxt       = count_r + CW'(1);
        end_matched_nxt = sts.end_done ? 3'd0 : end_adv;
        if (sts.end_done && sts.empty) begin
          begin_matched_nxt = '0;
          count_nxt         = '0;
          out_valid_nxt     = 1'b1;
          out_payload_nxt   = '0;
          out_status_nxt    = mdfe_pkg::ST_EMPTY;
          out_last_nxt      = 1'b1;
        end
      end
    end
    if (cmd.dump_out) begin
      out_valid_nxt   = 1'b1;
      out_payload_nxt = ram_q;
      out_status_nxt  = mdfe_pkg::ST_PAYLOAD;
      out_last_nxt    = sts.last_rd;
      rd_idx_nxt      = rd_idx_r + CW'(1);
      if (sts.last_rd) begin
        begin_matched_nxt = '0;
        end_matched_nxt   = '0;
        count_nxt         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_marker_r  <= '0;
      end_marker_r    <= '0;
      begin_matched_r <= '0;
      end_matched_r   <= '0;
      count_r         <= '0;
      rd_idx_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mdfe_pkg::CFG_BEGIN: begin_marker_r <= cfg_wdata;
          mdfe_pkg::CFG_END:   end_marker_r   <= cfg_wdata;
          default: ;
        endcase
      end
      begin_matched_r <= begin_matched_nxt;
      end_matched_r   <= end_matched_nxt;
      count_r         <= count_nxt;
      rd_idx_r        <= rd_idx_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_r <= in_rx_byte;
    end
    out_payload_r <= out_payload_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_payload_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(BUF_DEPTH))
    else $error("stored count above buffer depth");

  a_end_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    end_matched_r < 3'(mdfe_pkg::MARK_LEN))
    else $error("end match count reached marker length");

  a_hunt_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (begin_matched_r < 3'(mdfe_pkg::MARK_LEN)) |-> (count_r == '0))
    else $error("bytes stored while hunting for begin marker");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(cmd.dump_out || (cmd.eval && sts.ovf)))
    else $error("result register loaded while stalled");

  a_dump_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (rd_idx_r < frame_len))
    else $error("dump read beyond frame length");
`endif

endmodule

FILE: src/marker_delimited_frame_extractor.sv
// marker delimited frame extractor
// input channel: in_valid/in_ready with in_rx_byte, one received byte per transaction
// result channel: out_valid/out_ready with out_payload_byte, out_status, out_last
// config port: cfg_we, cfg_index (0 begin marker, 1 end marker), cfg_wdata, low byte first
// hunts for the begin marker, stores bytes until the end marker, then dumps the payload
// out_status: 0 payload byte, 1 empty frame, 2 overflow (byte dropped, state cleared)
// out_last marks the final result caused by a byte
// a byte that gives no result passes through the evaluate state before in_ready returns
// a status result is loaded in the evaluate state and is valid together with in_ready
// a frame dump steps through the evaluate state, then alternates a read state, which
// registers a read of the frame store, and an output state, which loads one payload byte
// into the result register; in_ready stays low until the last byte is loaded
// a stalled receiver holds the result register and freezes the dump
// reset clears marker registers, match counters and the stored count; store contents
// are not cleared, only entries written in the current frame are read
module marker_delimited_frame_extractor #(
  parameter int BUF_DEPTH = mdfe_pkg::BUF_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [mdfe_pkg::CFG_WIDTH-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_payload_byte,
  output logic [1:0]                     out_status,
  output logic                           out_last
);

  mdfe_pkg::cmd_t cmd;
  mdfe_pkg::sts_t sts;

  mdfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mdfe_dp #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_status       (out_status),
    .out_last         (out_last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

FILE: tb/sv/marker_delimited_frame_extractor_tb.sv
typedef struct packed {
  logic [7:0] data;
  logic [1:0] status;
  logic       last;
} frame_result_t;

class deframe_tracker;
  logic [31:0]   begin_mark;
  logic [31:0]   end_mark;
  logic [2:0]    begin_hits;
  logic [2:0]    end_hits;
  int            fill;
  logic [7:0]    held [mdfe_pkg::BUF_DEPTH_DEF];
  frame_result_t due[$];
  int            errors;
  int            payloads;
  int            empties;
  int            overflows;

  function new();
    begin_mark = '0;
    end_mark   = '0;
    errors     = 0;
    payloads   = 0;
    empties    = 0;
    overflows  = 0;
    drop_frame();
  endfunction

  function void drop_frame();
    begin_hits = '0;
    end_hits   = '0;
    fill       = 0;
  endfunction

  function void set_marker(logic idx, logic [31:0] value);
    if (idx == mdfe_pkg::CFG_BEGIN) begin
      begin_mark = value;
    end else begin
      end_mark = value;
    end
  endfunction

  // partial match restarts only on the first marker byte
  function logic [2:0] next_match(logic [31:0] mark, logic [2:0] hits, logic [7:0] v);
    logic [7:0] want;
    want = 8'(mark >> (8 * hits[1:0]));
    if (hits < 3'(mdfe_pkg::MARK_LEN) && v == want) begin
      return hits + 3'd1;
    end
    return (v == mark[7:0]) ? 3'd1 : 3'd0;
  endfunction

  function void push(logic [7:0] data, logic [1:0] status, logic last);
    frame_result_t r;
    r.data   = data;
    r.status = status;
    r.last   = last;
    due.push_back(r);
  endfunction

  function void note_rx_byte(logic [7:0] v);
    int len;
    int i;
    if (fill >= mdfe_pkg::BUF_DEPTH_DEF) begin
      drop_frame();
      push(8'h00, mdfe_pkg::ST_OVF, 1'b1);
      overflows++;
      return;
    end
    if (begin_hits < 3'(mdfe_pkg::MARK_LEN)) begin
      begin_hits = next_match(begin_mark, begin_hits, v);
      return;
    end
    held[fill] = v;
    fill++;
    end_hits = next_match(end_mark, end_hits, v);
    if (end_hits < 3'(mdfe_pkg::MARK_LEN)) begin
      return;
    end
    len = fill - mdfe_pkg::MARK_LEN;
    if (len <= 0) begin
      push(8'h00, mdfe_pkg::ST_EMPTY, 1'b1);
      empties++;
    end else begin
      for (i = 0; i < len; i++) begin
        push(held[i], mdfe_pkg::ST_PAYLOAD, i == len - 1);
      end
      payloads += len;
    end
    drop_frame();
  endfunction

  function void check_frame_result(logic [7:0] data, logic [1:0] status, logic last);
    frame_result_t want;
    if (due.size() == 0) begin
      $error("unexpected transaction: payload_byte %h status %0d last %0d",
             data, status, last);
      errors++;
      return;
    end
    want = due.pop_front();
    if (data !== want.data) begin
      $error("payload_byte mismatch: expected %h, actual %h", want.data, data);
      errors++;
    end
    if (status !== want.status) begin
      $error("status mismatch: expected %0d, actual %0d", want.status, status);
      errors++;
    end
    if (last !== want.last) begin
      $error("last mismatch: expected %0d, actual %0d", want.last, last);
      errors++;
    end
  endfunction
endclass

module marker_delimited_frame_extractor_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES      = 5;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_payload_byte;
  logic [1:0]  out_status;
  logic        out_last;

  deframe_tracker tracker;
  bit             quiet;
  logic [31:0]    cur_begin;
  logic [31:0]    cur_end;
  int             frame_bytes;
  int             frames_sent;
  int             settings_used;
  int             cycles = 0;
  logic [31:0]    begin_set [PHASES];
  logic [31:0]    end_set [PHASES];

  marker_delimited_frame_extractor u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_payload_byte(out_payload_byte),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        tracker.check_frame_result(out_payload_byte, out_status, out_last);
      end
      if (in_valid && in_ready) begin
        tracker.note_rx_byte(in_rx_byte);
      end
    end
  end

  // result side stall
  initial begin
    int k;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      k = quiet ? 0 : $urandom_range(0, 7);
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counted) frame_bytes++;
    @(negedge clk);
  endtask

  task automatic send_marker(input logic [31:0] mark);
    int k;
    for (k = 0; k < mdfe_pkg::MARK_LEN; k++) begin
      send_byte(mark[8*k +: 8], 1'b1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_markers(input logic [31:0] b, input logic [31:0] e);
    cfg_we    <= 1'b1;
    cfg_index <= mdfe_pkg::CFG_BEGIN;
    cfg_wdata <= b;
    @(posedge clk);
    tracker.set_marker(mdfe_pkg::CFG_BEGIN, b);
    @(negedge clk);
    cfg_index <= mdfe_pkg::CFG_END;
    cfg_wdata <= e;
    @(posedge clk);
    tracker.set_marker(mdfe_pkg::CFG_END, e);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_begin = b;
    cur_end   = e;
    settings_used++;
  endtask

  // noise, possibly a broken begin match, then a frame with random content that may lack its end marker
  task automatic random_frame();
    int pre;
    int len;
    int i;
    int k;
    int n;
    logic [7:0] b;
    quiet = ($urandom_range(0, 3) == 0);
    pre = $urandom_range(0, 3);
    for (i = 0; i < pre; i++) begin
      if ($urandom_range(0, 1) == 1) begin
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
          send_byte(cur_begin[8*k +: 8], 1'b0);
        end
      end else begin
        send_byte(8'($urandom), 1'b0);
      end
    end
    send_marker(cur_begin);
    len = ($urandom_range(0, 23) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 12);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        k = $urandom_range(0, 3);
        b = cur_end[8*k +: 8];
      end else begin
        b = 8'($urandom);
      end
      send_byte(b, 1'b1);
    end
    if ($urandom_range(0, 9) != 0) begin
      send_marker(cur_end);
    end
    frames_sent++;
  endtask

  task automatic overflow_frame();
    int i;
    quiet = 1'b0;
    send_marker(cur_begin);
    for (i = 0; i < mdfe_pkg::BUF_DEPTH_DEF + 2; i++) begin
      send_byte(8'($urandom), 1'b1);
    end
    frames_sent++;
  endtask

  initial begin
    int p;
    int target;
    int nframes;
    in_valid      = 1'b0;
    in_rx_byte    = 8'h00;
    cfg_we        = 1'b0;
    cfg_index     = mdfe_pkg::CFG_BEGIN;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    quiet         = 1'b0;
    frame_bytes   = 0;
    frames_sent   = 0;
    settings_used = 0;
    tracker       = new();
    begin_set[0] = 32'h7E5AA5C3; end_set[0] = 32'h0D0A0D0A;
    begin_set[1] = 32'h00000000; end_set[1] = 32'hFFFFFFFF;
    begin_set[2] = 32'hFFFFFFFF; end_set[2] = 32'h00000000;
    begin_set[3] = $urandom;     end_set[3] = $urandom;
    begin_set[4] = 32'h12121212; end_set[4] = 32'h12121212;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_markers(begin_set[0], end_set[0]);

    // broken begin match restarting on the first marker byte
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h7E, 1'b0);
    // empty frame
    send_marker(end_set[0]);
    // extreme bytes, then end marker bytes that with the first half of the end marker close the frame
    send_marker(begin_set[0]);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_marker(end_set[0]);
    frames_sent += 2;
    frame_bytes = 0;

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        write_markers(begin_set[p], end_set[p]);
      end
      target = frame_bytes + 48;
      nframes = 0;
      while (frame_bytes < target) begin
        if (p == 0 && nframes == 0) begin
          overflow_frame();
        end else begin
          random_frame();
        end
        nframes++;
        if (p == 0 && nframes == 3) settle();
      end
    end

    quiet = 1'b0;
    settle();
    repeat (20) @(negedge clk);
    $display("%0d frames, %0d frame bytes under %0d marker settings", frames_sent,
             frame_bytes, settings_used);
    $display("results: %0d payload bytes, %0d empty frames, %0d overflows",
             tracker.payloads, tracker.empties, tracker.overflows);
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
